[sv/chpe_pkg.sv]
package chpe_pkg;

	// payload types
	typedef logic signed [17:0] tparam_t;
	typedef logic signed [15:0] q88_t;
	typedef logic [47:0]        vec3_t;
	typedef logic [15:0]        scale_t;
	typedef logic [47:0]        cfg_data_t;
	typedef logic [2:0]         cfg_idx_t;

	// register indexes of the configuration channel
	localparam cfg_idx_t CFG_START_POINT   = 3'd0;
	localparam cfg_idx_t CFG_END_POINT     = 3'd1;
	localparam cfg_idx_t CFG_START_TANGENT = 3'd2;
	localparam cfg_idx_t CFG_END_TANGENT   = 3'd3;
	localparam cfg_idx_t CFG_TANGENT_SCALE = 3'd4;

	// register reset values
	localparam vec3_t  VEC_RESET   = 48'd0;
	localparam scale_t SCALE_RESET = 16'd256;

	// t = 1.0 in Q1.16
	localparam tparam_t T_ONE = 18'sd65536;

	// what a stage carries: curve point or one of the clamped endpoints
	typedef enum logic [1:0] {
		SEL_CURVE = 2'd0,
		SEL_START = 2'd1,
		SEL_END   = 2'd2
	} sel_t;

endpackage

[sv/chpe_channels.sv]
// input channel: one curve parameter per transaction
interface chpe_param_if;
	import chpe_pkg::*;
	logic    valid;
	logic    ready;
	tparam_t param_t;
	modport source (output valid, output param_t, input ready);
	modport sink (input valid, input param_t, output ready);
endinterface

// output channel: one curve point per transaction
interface chpe_point_if;
	import chpe_pkg::*;
	logic valid;
	logic ready;
	q88_t pos_x;
	q88_t pos_y;
	q88_t pos_z;
	logic saturated;
	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output saturated, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input saturated, output ready);
endinterface

// configuration write channel
interface chpe_cfg_if;
	import chpe_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/cubic_hermite_point_eval_unit.sv]
// throughput: one parameter per cycle unless the output stalls
// six pipeline stages, the last being the output register, each with its own valid bit,
// so bubbles close up and a stalled output only holds the stages behind it
// configuration writes are always ready and go straight into the registers
// reset: asynchronous, clears the valid bits and loads the register reset values
module cubic_hermite_point_eval_unit (
	input  logic                clk,
	input  logic                arst_n,
	chpe_param_if.sink          param,
	chpe_point_if.source        point,
	chpe_cfg_if.sink            cfg
);
	import chpe_pkg::*;

	// configuration registers
	vec3_t  start_point_q;
	vec3_t  end_point_q;
	vec3_t  start_tangent_q;
	vec3_t  end_tangent_q;
	scale_t tangent_scale_q;

	// pipeline valid bits and stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	// stage payloads
	sel_t              sel_s1, sel_s2, sel_s3, sel_s4, sel_s5, sel_s6;
	logic [15:0]       t_s1, t_s2;
	logic [31:0]       t2_s1, t2_s2;
	logic [47:0]       t3_s2;
	logic signed [17:0] b00_s3, b10_s3, b01_s3, b11_s3;
	logic signed [34:0] w_s4 [4];
	logic signed [50:0] prod_s5 [3][4];
	q88_t              pos_s6 [3];
	logic              sat_s6;

	// combinational helpers
	sel_t               sel_c;
	logic [15:0]        t_c;
	logic signed [51:0] t3x, t2sx, tshx;
	logic signed [51:0] n00, n10, n01, n11;
	logic signed [34:0] w_c [4];
	vec3_t              vec_c [4];
	logic signed [50:0] prod_c [3][4];
	logic signed [52:0] acc_c;
	logic signed [52:0] rnd_c;
	q88_t               pos_c [3];
	logic               sat_c;

	// round to nearest (halves up) after dropping 32 fraction bits
	function automatic logic signed [17:0] round32(input logic signed [51:0] n);
		logic signed [51:0] a;
		a = n + (52'sd1 <<< 31);
		return a[49:32];
	endfunction

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_point_q   <= VEC_RESET;
			end_point_q     <= VEC_RESET;
			start_tangent_q <= VEC_RESET;
			end_tangent_q   <= VEC_RESET;
			tangent_scale_q <= SCALE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_START_POINT:   start_point_q   <= cfg.data;
				CFG_END_POINT:     end_point_q     <= cfg.data;
				CFG_START_TANGENT: start_tangent_q <= cfg.data;
				CFG_END_TANGENT:   end_tangent_q   <= cfg.data;
				CFG_TANGENT_SCALE: tangent_scale_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when empty or when the next one moves
	always_comb begin
		en6 = !v_s6 || point.ready;
		en5 = !v_s5 || en6;
		en4 = !v_s4 || en5;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
	end

	assign param.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= param.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: classify t and square it
	always_comb begin
		t_c = param.param_t[15:0];
		if (param.param_t <= 18'sd0) begin
			sel_c = SEL_START;
		end else if (param.param_t >= T_ONE) begin
			sel_c = SEL_END;
		end else begin
			sel_c = SEL_CURVE;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && param.valid) begin
			sel_s1 <= sel_c;
			t_s1   <= t_c;
			t2_s1  <= 32'(t_c) * 32'(t_c);
		end
	end

	// stage 2: cube
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			sel_s2 <= sel_s1;
			t_s2   <= t_s1;
			t2_s2  <= t2_s1;
			t3_s2  <= 48'(t2_s1) * 48'(t_s1);
		end
	end

	// stage 3: basis values in Q0.48, rounded to Q0.16
	always_comb begin
		t3x  = signed'({4'b0, t3_s2});
		t2sx = signed'({4'b0, t2_s2, 16'b0});
		tshx = signed'({4'b0, t_s2, 32'b0});
		n00  = 52'sd2 * t3x - 52'sd3 * t2sx + (52'sd1 <<< 48);
		n10  = t3x - 52'sd2 * t2sx + tshx;
		n01  = 52'sd3 * t2sx - 52'sd2 * t3x;
		n11  = t3x - t2sx;
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			sel_s3 <= sel_s2;
			b00_s3 <= round32(n00);
			b10_s3 <= round32(n10);
			b01_s3 <= round32(n01);
			b11_s3 <= round32(n11);
		end
	end

	// stage 4: weights in Q.24, tangent weights scaled by the tension
	always_comb begin
		w_c[0] = {{9{b00_s3[17]}}, b00_s3, 8'b0};
		w_c[1] = 35'(b10_s3) * 35'(signed'({1'b0, tangent_scale_q}));
		w_c[2] = {{9{b01_s3[17]}}, b01_s3, 8'b0};
		w_c[3] = 35'(b11_s3) * 35'(signed'({1'b0, tangent_scale_q}));
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			sel_s4 <= sel_s3;
			for (int j = 0; j < 4; j++) begin
				w_s4[j] <= w_c[j];
			end
		end
	end

	// stage 5: weight times component, twelve products
	always_comb begin
		vec_c[0] = start_point_q;
		vec_c[1] = start_tangent_q;
		vec_c[2] = end_point_q;
		vec_c[3] = end_tangent_q;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 4; j++) begin
				prod_c[k][j] = 51'(w_s4[j]) * 51'(signed'(vec_c[j][16*k +: 16]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			sel_s5 <= sel_s4;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s5[k][j] <= prod_c[k][j];
				end
			end
		end
	end

	// stage 6: sum, round to Q8.8, saturate, or pass an endpoint through
	always_comb begin
		sat_c = 1'b0;
		acc_c = '0;
		rnd_c = '0;
		for (int k = 0; k < 3; k++) begin
			acc_c = 53'(prod_s5[k][0]) + 53'(prod_s5[k][1])
				+ 53'(prod_s5[k][2]) + 53'(prod_s5[k][3]);
			rnd_c = (acc_c + 53'sd8388608) >>> 24;
			case (sel_s5)
				SEL_START: pos_c[k] = start_point_q[16*k +: 16];
				SEL_END:   pos_c[k] = end_point_q[16*k +: 16];
				default: begin
					if (rnd_c > 53'sd32767) begin
						pos_c[k] = 16'sh7fff;
						sat_c    = 1'b1;
					end else if (rnd_c < -53'sd32768) begin
						pos_c[k] = 16'sh8000;
						sat_c    = 1'b1;
					end else begin
						pos_c[k] = rnd_c[15:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			sel_s6 <= sel_s5;
			sat_s6 <= sat_c;
			for (int k = 0; k < 3; k++) begin
				pos_s6[k] <= pos_c[k];
			end
		end
	end

	// output register drives the result channel
	assign point.valid     = v_s6;
	assign point.pos_x     = pos_s6[0];
	assign point.pos_y     = pos_s6[1];
	assign point.pos_z     = pos_s6[2];
	assign point.saturated = (sel_s6 == SEL_CURVE) && sat_s6;

endmodule

[sv/chpe_checker.sv]
module chpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        param_valid,
	input logic        param_ready,
	input logic        point_valid,
	input logic        point_ready,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	input logic [15:0] pos_z,
	input logic        saturated
);
	localparam int PipeDepth = 6;

	logic       in_acc;
	logic       out_acc;
	logic [2:0] cnt_q;

	assign in_acc  = param_valid && param_ready;
	assign out_acc = point_valid && point_ready;

	// items in flight between the two channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	// a stalled result keeps its transaction pending
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> point_valid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> $stable({pos_x, pos_y, pos_z, saturated}))
		else $error("result payload changed while stalled");

	// every result belongs to an accepted parameter
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> cnt_q != 3'd0)
		else $error("result without an accepted parameter");

	// no more items in flight than the pipeline holds
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(PipeDepth))
		else $error("more items in flight than pipeline stages");

	// input back-pressure only when the output is stalled
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!param_ready |-> point_valid && !point_ready)
		else $error("input stalled while output is free");

endmodule

bind cubic_hermite_point_eval_unit chpe_checker u_chpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.param_valid (param.valid),
	.param_ready (param.ready),
	.point_valid (point.valid),
	.point_ready (point.ready),
	.pos_x       (point.pos_x),
	.pos_y       (point.pos_y),
	.pos_z       (point.pos_z),
	.saturated   (point.saturated)
);

[sim/tb_cubic_hermite_point_eval_unit.sv]
module tb_cubic_hermite_point_eval_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import chpe_pkg::*;

	// index that decodes to no register
	localparam cfg_idx_t CFG_UNUSED_IDX = 3'd7;

	// one curve point as the output channel carries it
	typedef struct {
		q88_t pos [3];
		logic sat;
	} curve_point_t;

	logic clk;
	logic arst_n;

	chpe_param_if param_ch ();
	chpe_point_if point_ch ();
	chpe_cfg_if   cfg_ch ();

	cubic_hermite_point_eval_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.param  (param_ch),
		.point  (point_ch),
		.cfg    (cfg_ch)
	);

	// shadow copy of the curve registers
	vec3_t  cur_p0;
	vec3_t  cur_p1;
	vec3_t  cur_t0;
	vec3_t  cur_t1;
	scale_t cur_scale;

	curve_point_t pending_points [$];
	int unsigned  mismatches;
	bit           gaps_on;
	bit           stalls_on;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor((v + 2^(s-1)) / 2^s)
	function automatic longint round_shift(longint v, int s);
		longint a;
		a = v + (longint'(1) << (s - 1));
		return a >>> s;
	endfunction

	// signed q8.8 component k of a packed vector
	function automatic longint component(vec3_t v, int k);
		q88_t c;
		c = v[16 * k +: 16];
		return longint'(c);
	endfunction

	// expected point for one curve parameter under the current registers
	function automatic curve_point_t predict_point(tparam_t t);
		curve_point_t r;
		longint tl, t2, t3, t2s, one;
		longint b00, b10, b01, b11, w00, w10, w01, w11, acc, v;
		vec3_t endp;
		r.sat = 1'b0;
		tl = longint'(t);
		// parameter outside the open interval gives an endpoint as is
		if (tl <= 0 || tl >= longint'(T_ONE)) begin
			endp = (tl <= 0) ? cur_p0 : cur_p1;
			for (int k = 0; k < 3; k++)
				r.pos[k] = endp[16 * k +: 16];
			return r;
		end
		// basis values exact in q0.48, rounded to q0.16
		t2 = tl * tl;
		t3 = t2 * tl;
		t2s = t2 * 65536;
		one = longint'(1) << 48;
		b00 = round_shift(2 * t3 - 3 * t2s + one, 32);
		b10 = round_shift(t3 - 2 * t2s + tl * (longint'(1) << 32), 32);
		b01 = round_shift(-2 * t3 + 3 * t2s, 32);
		b11 = round_shift(t3 - t2s, 32);
		w00 = b00 * 256;
		w10 = b10 * longint'(cur_scale);
		w01 = b01 * 256;
		w11 = b11 * longint'(cur_scale);
		for (int k = 0; k < 3; k++) begin
			acc = w00 * component(cur_p0, k) + w10 * component(cur_t0, k)
				+ w01 * component(cur_p1, k) + w11 * component(cur_t1, k);
			v = round_shift(acc, 24);
			if (v > 32767) begin
				v = 32767;
				r.sat = 1'b1;
			end
			if (v < -32768) begin
				v = -32768;
				r.sat = 1'b1;
			end
			r.pos[k] = v[15:0];
		end
		return r;
	endfunction

	// one parameter transaction, with an occasional gap before it
	task automatic send_param(tparam_t t);
		int n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 9);
			repeat (n) begin
				@(negedge clk);
				param_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		param_ch.valid <= 1'b1;
		param_ch.param_t <= t;
		@(posedge clk);
		while (!param_ch.ready)
			@(posedge clk);
		pending_points.insert(pending_points.size(), predict_point(t));
	endtask

	// stop sending and let every outstanding point come back
	task automatic wait_idle();
		@(negedge clk);
		param_ch.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// one register write transaction; valid is left high for the next one
	task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_START_POINT:   cur_p0 = d;
			CFG_END_POINT:     cur_p1 = d;
			CFG_START_TANGENT: cur_t0 = d;
			CFG_END_TANGENT:   cur_t1 = d;
			CFG_TANGENT_SCALE: cur_scale = d[15:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// reload the whole curve while the pipeline is empty
	task automatic set_curve(vec3_t p0, vec3_t p1, vec3_t t0, vec3_t t1, cfg_data_t s);
		wait_idle();
		write_reg(CFG_START_POINT, p0);
		write_reg(CFG_END_POINT, p1);
		write_reg(CFG_START_TANGENT, t0);
		write_reg(CFG_END_TANGENT, t1);
		write_reg(CFG_TANGENT_SCALE, s);
		end_writes();
	endtask

	// packed vector, either any bits or components of modest size
	function automatic vec3_t rand_vec(bit tame);
		vec3_t v;
		q88_t c;
		v[31:0] = $urandom();
		v[47:32] = 16'($urandom_range(0, 16'hFFFF));
		if (tame) begin
			for (int k = 0; k < 3; k++) begin
				c = q88_t'(int'($urandom_range(0, 4095)) - 2048);
				v[16 * k +: 16] = c;
			end
		end
		return v;
	endfunction

	// scale write data with junk above the register width
	function automatic cfg_data_t rand_scale();
		cfg_data_t d;
		d[47:16] = $urandom();
		case ($urandom_range(0, 4))
			0: d[15:0] = 16'hFFFF;
			1: d[15:0] = 16'h0001;
			2: d[15:0] = 16'h0000;
			default: d[15:0] = 16'($urandom_range(0, 16'hFFFF));
		endcase
		return d;
	endfunction

	// mostly interior parameters, some on the edges, some anywhere
	function automatic tparam_t rand_param();
		case ($urandom_range(0, 9))
			0: return tparam_t'($urandom());
			1: begin
				case ($urandom_range(0, 4))
					0: return tparam_t'(0);
					1: return tparam_t'(1);
					2: return tparam_t'(65535);
					3: return T_ONE;
					default: return tparam_t'(-1);
				endcase
			end
			default: return tparam_t'($urandom_range(1, 65535));
		endcase
	endfunction

	// points before any register is written
	task automatic test_reset_values();
		send_param(tparam_t'(0));
		send_param(tparam_t'(32768));
		send_param(T_ONE);
	endtask

	// parameters clamped to either endpoint
	task automatic test_endpoint_clamp();
		set_curve(rand_vec(1'b0), rand_vec(1'b0), rand_vec(1'b0), rand_vec(1'b0),
			48'd256);
		send_param(tparam_t'(-131072));
		send_param(tparam_t'(-65536));
		send_param(tparam_t'(-1));
		send_param(tparam_t'(0));
		send_param(T_ONE);
		send_param(tparam_t'(65537));
		send_param(tparam_t'(131071));
	endtask

	// interior points with the smallest nonzero tension
	task automatic test_interior();
		set_curve(rand_vec(1'b1), rand_vec(1'b1), rand_vec(1'b1), rand_vec(1'b1),
			48'd1);
		send_param(tparam_t'(1));
		send_param(tparam_t'(16384));
		send_param(tparam_t'(32768));
		send_param(tparam_t'(65535));
	endtask

	// full scale components and largest tension clip both ways
	task automatic test_saturation();
		set_curve({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h7FFF},
			{16'h0000, 16'h8000, 16'h7FFF}, {16'h0000, 16'h7FFF, 16'h8000},
			{32'h0, 16'hFFFF});
		send_param(tparam_t'(16384));
		send_param(tparam_t'(32768));
		send_param(tparam_t'(49152));
	endtask

	// zero tension drops the tangent terms
	task automatic test_zero_tension();
		set_curve(rand_vec(1'b1), rand_vec(1'b1), rand_vec(1'b0), rand_vec(1'b0),
			{$urandom(), 16'h0000});
		send_param(tparam_t'(21845));
		send_param(tparam_t'(43690));
	endtask

	// a write to an unused index leaves the curve alone
	task automatic test_unused_index();
		wait_idle();
		write_reg(CFG_UNUSED_IDX, rand_vec(1'b0));
		end_writes();
		send_param(tparam_t'(10000));
		send_param(tparam_t'(60000));
	endtask

	// random curves, the last one with no idling on either side
	task automatic test_random_curves();
		for (int ph = 0; ph < 11; ph++) begin
			if (ph == 10) begin
				wait_idle();
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			set_curve(rand_vec($urandom_range(0, 3) != 0), rand_vec($urandom_range(0, 3) != 0),
				rand_vec($urandom_range(0, 3) != 0), rand_vec($urandom_range(0, 3) != 0),
				rand_scale());
			repeat (50)
				send_param(rand_param());
		end
	endtask

	// output ready with random stall bursts
	initial begin
		int n;
		point_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stalls_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 9);
				point_ch.ready <= 1'b0;
				repeat (n)
					@(negedge clk);
			end
			point_ch.ready <= 1'b1;
		end
	end

	// compare each point transaction with the oldest prediction
	always @(posedge clk) begin
		curve_point_t want;
		q88_t got [3];
		if (arst_n && point_ch.valid && point_ch.ready) begin
			got[0] = point_ch.pos_x;
			got[1] = point_ch.pos_y;
			got[2] = point_ch.pos_z;
			if (pending_points.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected point %0d %0d %0d sat %0b", $time,
					got[0], got[1], got[2], point_ch.saturated);
			end else begin
				want = pending_points.pop_front();
				for (int k = 0; k < 3; k++) begin
					if (got[k] !== want.pos[k]) begin
						mismatches++;
						$display("%0t: pos[%0d] expected %0d actual %0d", $time, k,
							want.pos[k], got[k]);
					end
				end
				if (point_ch.saturated !== want.sat) begin
					mismatches++;
					$display("%0t: saturated expected %0b actual %0b", $time,
						want.sat, point_ch.saturated);
				end
			end
		end
	end

	// test sequence
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		param_ch.valid = 1'b0;
		param_ch.param_t = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_START_POINT;
		cfg_ch.data = '0;
		cur_p0 = VEC_RESET;
		cur_p1 = VEC_RESET;
		cur_t0 = VEC_RESET;
		cur_t1 = VEC_RESET;
		cur_scale = SCALE_RESET;
		mismatches = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_endpoint_clamp();
		test_interior();
		test_saturation();
		test_zero_tension();
		test_unused_index();
		test_random_curves();

		// drain, then watch for stray points
		wait_idle();
		repeat (20)
			@(posedge clk);
		if (mismatches == 0)
			$display("tb_cubic_hermite_point_eval_unit OK");
		else
			$display("tb_cubic_hermite_point_eval_unit NOT OK");
		$finish;
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("tb_cubic_hermite_point_eval_unit NOT OK");
		$finish;
	end

endmodule
